// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define UTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define UTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/utc_pkg.sv
`default_nettype none

package utc_pkg;

    typedef enum logic [1:0] {
        ENC_SINGLE = 2'd0,
        ENC_UTF8   = 2'd1,
        ENC_UTF16  = 2'd2,
        ENC_UTF32  = 2'd3
    } enc_t;

    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_DEST   = 1'b1;

    localparam logic [7:0] SUBST_CHAR = 8'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_truncated;
    } out_word_t;

    // bytes of one encoded code point, byte 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } enc_result_t;

endpackage

`default_nettype wire

// File: hdl/unicode_transcoder.sv
// Byte-serial transcoder between single-byte, UTF-8, UTF-16LE and UTF-32LE. Source
// words enter one byte at a time on the in channel; every finished code point leaves
// as 1 to 4 bytes in the destination encoding on the out channel, one byte per word.
// With equal encodings bytes are copied unchanged, out_last following in_last. A
// stream that ends inside a character yields one word with out_truncated and out_last
// set and out_byte zero. Timing: an input byte is taken and its bytes appear on the out
// channel from the next cycle, one per cycle while out_stall is low; each input byte
// produces 0 to 4 bytes, sent by the byte-wide output serializer. A new input byte
// is taken in the cycle the last pending output byte leaves. Registers (APB, 32-bit):
// 0x0 source_encoding, 0x4 dest_encoding, codes 0 single byte, 1 UTF-8, 2 UTF-16LE,
// 3 UTF-32LE; any write clears the character state and must be done while the block
// is idle.
`default_nettype none

module unicode_transcoder (
    input  wire                     clk,
    input  wire                     rst_n,
    // source bytes
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire utc_pkg::in_word_t  in_data,
    // converted bytes
    output logic                    out_valid,
    input  wire                     out_stall,
    output utc_pkg::out_word_t      out_data,
    // configuration
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire [2:0]               paddr,
    input  wire [31:0]              pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // configuration registers
    utc_pkg::enc_t src_reg;
    utc_pkg::enc_t dst_reg;
    logic          cfg_wr;

    // character assembly state
    logic [31:0] acc_reg,       acc_next;
    logic [2:0]  collected_reg, collected_next;
    logic [2:0]  expected_reg,  expected_next;
    logic        sur_pend_reg,  sur_pend_next;
    logic [9:0]  sur_bits_reg,  sur_bits_next;

    // one decoded input byte worth of output bytes
    logic [3:0][7:0] pkt_bytes_reg, pkt_bytes_next;
    logic [2:0]      pkt_count_reg, pkt_count_next;
    logic            pkt_last_reg,  pkt_last_next;
    logic            pkt_trunc_reg, pkt_trunc_next;
    logic            pkt_valid_reg;
    logic [1:0]      idx_reg;

    logic        in_take;
    logic        out_take;
    logic        last_idx;
    logic        load;
    logic        done;
    logic [31:0] cp;
    logic [15:0] w16;
    logic [7:0]  b;

    utc_pkg::enc_result_t enc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            utc_pkg::REG_SOURCE: prdata[1:0] = src_reg;
            utc_pkg::REG_DEST:   prdata[1:0] = dst_reg;
            default:             prdata      = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= utc_pkg::ENC_SINGLE;
            dst_reg <= utc_pkg::ENC_SINGLE;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == utc_pkg::REG_SOURCE)
            begin
                src_reg <= utc_pkg::enc_t'(pwdata[1:0]);
            end
            else
            begin
                dst_reg <= utc_pkg::enc_t'(pwdata[1:0]);
            end
        end
    end

    // handshakes: the packet buffer frees up in the cycle its final byte is taken
    assign out_valid = pkt_valid_reg;
    assign out_take  = out_valid && !out_stall;
    assign last_idx  = ({1'b0, idx_reg} == (pkt_count_reg - 3'd1));
    assign in_stall  = pkt_valid_reg && !(out_take && last_idx);
    assign in_take   = in_valid && !in_stall;

    assign out_data.out_byte      = pkt_bytes_reg[idx_reg];
    assign out_data.out_last      = pkt_last_reg && last_idx;
    assign out_data.out_truncated = pkt_trunc_reg;

    assign b   = in_data.in_byte;
    assign w16 = {b, acc_reg[7:0]};

    // decode: update the assembly state and flag a finished code point
    always_comb
    begin
        acc_next       = acc_reg;
        collected_next = collected_reg;
        expected_next  = expected_reg;
        sur_pend_next  = sur_pend_reg;
        sur_bits_next  = sur_bits_reg;
        done           = 1'b0;
        cp             = '0;
        unique case (src_reg)
            utc_pkg::ENC_SINGLE:
            begin
                cp   = {24'd0, b};
                done = 1'b1;
            end
            utc_pkg::ENC_UTF8:
            begin
                if (collected_reg == 3'd0)
                begin
                    if (!b[7])
                    begin
                        cp   = {24'd0, b};
                        done = 1'b1;
                    end
                    else
                    begin
                        // lead class from bits 5 and 4 only
                        if (b[5] && b[4])
                        begin
                            acc_next      = {29'd0, b[2:0]};
                            expected_next = 3'd4;
                        end
                        else if (b[5])
                        begin
                            acc_next      = {28'd0, b[3:0]};
                            expected_next = 3'd3;
                        end
                        else
                        begin
                            acc_next      = {27'd0, b[4:0]};
                            expected_next = 3'd2;
                        end
                        collected_next = 3'd1;
                    end
                end
                else
                begin
                    acc_next       = {acc_reg[25:0], b[5:0]};
                    collected_next = collected_reg + 3'd1;
                    if (collected_next >= expected_reg)
                    begin
                        cp             = acc_next;
                        done           = 1'b1;
                        acc_next       = '0;
                        collected_next = 3'd0;
                        expected_next  = 3'd0;
                    end
                end
            end
            utc_pkg::ENC_UTF16:
            begin
                if (collected_reg == 3'd0)
                begin
                    acc_next       = {24'd0, b};
                    collected_next = 3'd1;
                    expected_next  = 3'd2;
                end
                else
                begin
                    acc_next       = '0;
                    collected_next = 3'd0;
                    expected_next  = 3'd0;
                    if (sur_pend_reg)
                    begin
                        // second word pairs whatever it is
                        cp            = {12'd0, sur_bits_reg, w16[9:0]} + 32'h0001_0000;
                        sur_pend_next = 1'b0;
                        sur_bits_next = '0;
                        done          = 1'b1;
                    end
                    else if (w16[15:10] == 6'b110110)
                    begin
                        sur_pend_next = 1'b1;
                        sur_bits_next = w16[9:0];
                    end
                    else
                    begin
                        cp   = {16'd0, w16};
                        done = 1'b1;
                    end
                end
            end
            utc_pkg::ENC_UTF32:
            begin
                acc_next       = acc_reg | ({24'd0, b} << {collected_reg[1:0], 3'b000});
                collected_next = collected_reg + 3'd1;
                expected_next  = 3'd4;
                if (collected_next >= 3'd4)
                begin
                    cp             = acc_next;
                    done           = 1'b1;
                    acc_next       = '0;
                    collected_next = 3'd0;
                    expected_next  = 3'd0;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
        // stream ends mid character
        if (!done && in_data.in_last)
        begin
            acc_next       = '0;
            collected_next = 3'd0;
            expected_next  = 3'd0;
            sur_pend_next  = 1'b0;
            sur_bits_next  = '0;
        end
    end

    utc_encode u_encode (
        .dest   (dst_reg),
        .cp     (cp),
        .result (enc)
    );

    // packet contents for the byte being accepted
    always_comb
    begin
        pkt_bytes_next = '0;
        pkt_count_next = 3'd1;
        pkt_last_next  = in_data.in_last;
        pkt_trunc_next = 1'b0;
        load           = 1'b0;
        if (src_reg == dst_reg)
        begin
            pkt_bytes_next[0] = b;
            load              = in_take;
        end
        else if (done)
        begin
            pkt_bytes_next = enc.bytes;
            pkt_count_next = enc.count;
            load           = in_take;
        end
        else if (in_data.in_last)
        begin
            pkt_trunc_next = 1'b1;
            load           = in_take;
        end
    end

    // assembly state, left alone in pass-through, cleared by any register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            collected_reg <= '0;
            expected_reg  <= '0;
            sur_pend_reg  <= 1'b0;
            sur_bits_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            acc_reg       <= '0;
            collected_reg <= '0;
            expected_reg  <= '0;
            sur_pend_reg  <= 1'b0;
            sur_bits_reg  <= '0;
        end
        else if (in_take && (src_reg != dst_reg))
        begin
            acc_reg       <= acc_next;
            collected_reg <= collected_next;
            expected_reg  <= expected_next;
            sur_pend_reg  <= sur_pend_next;
            sur_bits_reg  <= sur_bits_next;
        end
    end

    // output serializer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            pkt_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (out_take)
        begin
            if (last_idx)
            begin
                pkt_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_bytes_reg <= pkt_bytes_next;
            pkt_count_reg <= pkt_count_next;
            pkt_last_reg  <= pkt_last_next;
            pkt_trunc_reg <= pkt_trunc_next;
        end
    end

`include "assert_macros.svh"

    `UTC_ASSERT(a_idx_in_range, clk, rst_n, pkt_valid_reg |-> ({1'b0, idx_reg} < pkt_count_reg), "serializer index past packet end")
    `UTC_ASSERT(a_trunc_form, clk, rst_n, (out_valid && out_data.out_truncated) |-> (out_data.out_last && (out_data.out_byte == 8'd0) && (pkt_count_reg == 3'd1)), "truncated word malformed")
    `UTC_ASSERT(a_no_overrun, clk, rst_n, (in_take && pkt_valid_reg) |-> (out_take && last_idx), "input taken over a pending packet")
    `UTC_ASSERT(a_idx_step, clk, rst_n, (out_take && !last_idx) |=> (idx_reg == ($past(idx_reg) + 2'd1)), "serializer skipped a byte")
    `UTC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "output valid during reset")

endmodule

`default_nettype wire

// File: hdl/utc_encode.sv
`default_nettype none

module utc_encode (
    input  wire utc_pkg::enc_t       dest,
    input  wire logic [31:0]         cp,
    output utc_pkg::enc_result_t     result
);

    logic [31:0] sub;

    assign sub = cp - 32'h0001_0000;

    always_comb
    begin
        result.bytes = '0;
        result.count = 3'd1;
        unique case (dest)
            utc_pkg::ENC_SINGLE:
            begin
                result.bytes[0] = (cp < 32'h100) ? cp[7:0] : utc_pkg::SUBST_CHAR;
            end
            utc_pkg::ENC_UTF8:
            begin
                if (cp > 32'hFFFF)
                begin
                    result.bytes[0] = {5'b11110, cp[20:18]};
                    result.bytes[1] = {2'b10, cp[17:12]};
                    result.bytes[2] = {2'b10, cp[11:6]};
                    result.bytes[3] = {2'b10, cp[5:0]};
                    result.count    = 3'd4;
                end
                else if (cp > 32'h7FF)
                begin
                    result.bytes[0] = {4'b1110, cp[15:12]};
                    result.bytes[1] = {2'b10, cp[11:6]};
                    result.bytes[2] = {2'b10, cp[5:0]};
                    result.count    = 3'd3;
                end
                else if (cp > 32'h7F)
                begin
                    result.bytes[0] = {3'b110, cp[10:6]};
                    result.bytes[1] = {2'b10, cp[5:0]};
                    result.count    = 3'd2;
                end
                else
                begin
                    result.bytes[0] = cp[7:0];
                end
            end
            utc_pkg::ENC_UTF16:
            begin
                if (cp > 32'hFFFF)
                begin
                    // high surrogate then low surrogate, little endian
                    result.bytes[0] = sub[17:10];
                    result.bytes[1] = {6'b110110, sub[19:18]};
                    result.bytes[2] = sub[7:0];
                    result.bytes[3] = {6'b110111, sub[9:8]};
                    result.count    = 3'd4;
                end
                else
                begin
                    result.bytes[0] = cp[7:0];
                    result.bytes[1] = cp[15:8];
                    result.count    = 3'd2;
                end
            end
            utc_pkg::ENC_UTF32:
            begin
                result.bytes = cp;
                result.count = 3'd4;
            end
            default:
            begin
                result.bytes = '0;
                result.count = 3'd1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: test/tb_unicode_transcoder.sv
module tb_unicode_transcoder;

    // quiet cycles after the last owed word before the block counts as idle
    localparam int SETTLE_CYCLES = 8;
    // hard stop, far beyond the slowest legal run
    localparam int RUN_LIMIT = 4000000;

    logic clk;
    logic rst_n = 1'b1;

    logic in_valid = 1'b0;
    logic in_stall;
    utc_pkg::in_word_t in_data = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    utc_pkg::out_word_t out_data;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    unicode_transcoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // converted bytes still owed by the block, oldest first
    utc_pkg::out_word_t owed_bytes[$];
    int errors = 0;
    int items_sent = 0;
    int burst_left = 0;
    int stall_left = 0;

    // our own copy of the encoding registers and the decoder state
    utc_pkg::enc_t src_enc = utc_pkg::ENC_SINGLE;
    utc_pkg::enc_t dst_enc = utc_pkg::ENC_SINGLE;
    logic [31:0] acc = '0;
    logic [2:0] got = '0;
    logic [2:0] need = '0;
    logic sur_pend = 1'b0;
    logic [9:0] sur_bits = '0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("unicode_transcoder: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] seen,
                                   input logic [7:0] want);
        errors++;
        $display("ERROR at %0t: %s got %h want %h", $realtime, what, seen, want);
    endtask

    task automatic clear_char_state();
        acc = '0;
        got = '0;
        need = '0;
        sur_pend = 1'b0;
        sur_bits = '0;
    endtask

    // bytes of one code point in a given encoding, byte 0 first
    function automatic utc_pkg::enc_result_t encode_cp(input utc_pkg::enc_t e,
                                                       input logic [31:0] c);
        utc_pkg::enc_result_t r;
        logic [31:0] s;
        logic [15:0] hi;
        logic [15:0] lo;
        r = '0;
        case (e)
            utc_pkg::ENC_SINGLE:
            begin
                r.bytes[0] = (c < 32'h100) ? c[7:0] : utc_pkg::SUBST_CHAR;
                r.count = 3'd1;
            end
            utc_pkg::ENC_UTF8:
            begin
                // oversized values keep only 3 bits in the lead byte
                if (c > 32'hFFFF)
                begin
                    r.bytes[0] = {5'b11110, c[20:18]};
                    r.bytes[1] = {2'b10, c[17:12]};
                    r.bytes[2] = {2'b10, c[11:6]};
                    r.bytes[3] = {2'b10, c[5:0]};
                    r.count = 3'd4;
                end
                else if (c > 32'h7FF)
                begin
                    r.bytes[0] = {4'b1110, c[15:12]};
                    r.bytes[1] = {2'b10, c[11:6]};
                    r.bytes[2] = {2'b10, c[5:0]};
                    r.count = 3'd3;
                end
                else if (c > 32'h7F)
                begin
                    r.bytes[0] = {3'b110, c[10:6]};
                    r.bytes[1] = {2'b10, c[5:0]};
                    r.count = 3'd2;
                end
                else
                begin
                    r.bytes[0] = c[7:0];
                    r.count = 3'd1;
                end
            end
            utc_pkg::ENC_UTF16:
            begin
                if (c > 32'hFFFF)
                begin
                    // offset wraps for huge values, halves masked to 10 bits
                    s = c - 32'h10000;
                    hi = {6'b110110, s[19:10]};
                    lo = {6'b110111, s[9:0]};
                    r.bytes[0] = hi[7:0];
                    r.bytes[1] = hi[15:8];
                    r.bytes[2] = lo[7:0];
                    r.bytes[3] = lo[15:8];
                    r.count = 3'd4;
                end
                else
                begin
                    r.bytes[0] = c[7:0];
                    r.bytes[1] = c[15:8];
                    r.count = 3'd2;
                end
            end
            default:
            begin
                r.bytes[0] = c[7:0];
                r.bytes[1] = c[15:8];
                r.bytes[2] = c[23:16];
                r.bytes[3] = c[31:24];
                r.count = 3'd4;
            end
        endcase
        return r;
    endfunction

    // decode one source byte and queue every converted byte it releases
    task automatic transcode_byte(input utc_pkg::in_word_t w);
        logic [7:0] b;
        logic lst;
        logic done;
        logic [31:0] cp;
        logic [15:0] w16;
        utc_pkg::enc_result_t r;
        utc_pkg::out_word_t o;
        b = w.in_byte;
        lst = w.in_last;
        done = 1'b0;
        cp = '0;
        if (src_enc == dst_enc)
        begin
            // straight copy, decoder state untouched
            o.out_byte = b;
            o.out_last = lst;
            o.out_truncated = 1'b0;
            owed_bytes.push_back(o);
        end
        else
        begin
            case (src_enc)
                utc_pkg::ENC_SINGLE:
                begin
                    cp = 32'(b);
                    done = 1'b1;
                end
                utc_pkg::ENC_UTF8:
                begin
                    if (got == 3'd0)
                    begin
                        if (!b[7])
                        begin
                            cp = 32'(b);
                            done = 1'b1;
                        end
                        else
                        begin
                            // lead length from bits 5 and 4 only
                            if (b[5] && b[4])
                            begin
                                acc = 32'(b[2:0]);
                                need = 3'd4;
                            end
                            else if (b[5])
                            begin
                                acc = 32'(b[3:0]);
                                need = 3'd3;
                            end
                            else
                            begin
                                acc = 32'(b[4:0]);
                                need = 3'd2;
                            end
                            got = 3'd1;
                        end
                    end
                    else
                    begin
                        // continuation top bits are not checked
                        acc = {acc[25:0], b[5:0]};
                        got = got + 3'd1;
                        if (got >= need)
                        begin
                            cp = acc;
                            done = 1'b1;
                            acc = '0;
                            got = '0;
                            need = '0;
                        end
                    end
                end
                utc_pkg::ENC_UTF16:
                begin
                    if (got == 3'd0)
                    begin
                        acc = 32'(b);
                        got = 3'd1;
                        need = 3'd2;
                    end
                    else
                    begin
                        w16 = {b, acc[7:0]};
                        acc = '0;
                        got = '0;
                        need = '0;
                        if (sur_pend)
                        begin
                            // any word completes a waiting high surrogate
                            cp = {12'd0, sur_bits, w16[9:0]} + 32'h10000;
                            sur_pend = 1'b0;
                            sur_bits = '0;
                            done = 1'b1;
                        end
                        else if (w16[15:10] == 6'b110110)
                        begin
                            sur_pend = 1'b1;
                            sur_bits = w16[9:0];
                        end
                        else
                        begin
                            cp = 32'(w16);
                            done = 1'b1;
                        end
                    end
                end
                default:
                begin
                    acc = acc | (32'(b) << (8 * got[1:0]));
                    got = got + 3'd1;
                    need = 3'd4;
                    if (got >= 3'd4)
                    begin
                        cp = acc;
                        done = 1'b1;
                        acc = '0;
                        got = '0;
                        need = '0;
                    end
                end
            endcase
            if (done)
            begin
                r = encode_cp(dst_enc, cp);
                for (int k = 0; k < int'(r.count); k++)
                begin
                    o.out_byte = r.bytes[k];
                    o.out_last = lst && (k == int'(r.count) - 1);
                    o.out_truncated = 1'b0;
                    owed_bytes.push_back(o);
                end
            end
            else if (lst)
            begin
                // stream ended inside a character
                clear_char_state();
                o.out_byte = 8'h00;
                o.out_last = 1'b1;
                o.out_truncated = 1'b1;
                owed_bytes.push_back(o);
            end
        end
    endtask

    // present one source word, with random bursts and gaps on the sender side
    task automatic send_word(input logic [7:0] b, input logic lst);
        utc_pkg::in_word_t w;
        int gap;
        w.in_byte = b;
        w.in_last = lst;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // long stretch with no idling
                gap = 0;
                burst_left = $urandom_range(30, 60);
            end
            else
            begin
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) :
                                                    $urandom_range(0, 3);
                burst_left = $urandom_range(1, 20);
            end
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_data <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
        transcode_byte(w);
    endtask

    // hold the sender until every owed byte has left and the block is quiet
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (owed_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup and access cycles, then the bus goes idle
    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // both writes clear the decoder state
    task automatic set_encodings(input utc_pkg::enc_t s, input utc_pkg::enc_t d);
        wait_for_drain();
        apb_write(utc_pkg::REG_SOURCE, 32'(s));
        src_enc = s;
        clear_char_state();
        apb_write(utc_pkg::REG_DEST, 32'(d));
        dst_enc = d;
        clear_char_state();
    endtask

    // one mostly well-formed character in the source encoding, last flag at random
    task automatic send_char(input utc_pkg::enc_t s);
        logic [31:0] cp;
        utc_pkg::enc_result_t r;
        case ($urandom_range(0, 9))
            0, 1, 2: cp = $urandom_range(0, 32'h7F);
            3, 4: cp = $urandom_range(32'h80, 32'h7FF);
            5, 6: cp = $urandom_range(32'h800, 32'hFFFF);
            7, 8: cp = $urandom_range(32'h10000, 32'h10FFFF);
            default: cp = $urandom;
        endcase
        if (s == utc_pkg::ENC_SINGLE)
            cp = cp & 32'hFF;
        r = encode_cp(s, cp);
        for (int k = 0; k < int'(r.count); k++)
            send_word(r.bytes[k], $urandom_range(0, 15) == 0);
    endtask

    // equal encodings copy bytes, field extremes included
    task automatic test_passthrough();
        set_encodings(utc_pkg::ENC_UTF8, utc_pkg::ENC_UTF8);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    // ascii, lone continuation as a two-byte lead, 0xF8 as a four-byte lead,
    // and a stream cut after a lead byte
    task automatic test_utf8_leads();
        set_encodings(utc_pkg::ENC_UTF8, utc_pkg::ENC_UTF32);
        send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hF8, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b1);
        send_word(8'hE0, 1'b1);
    endtask

    // high surrogate paired with a plain word, lone low surrogate, half word at end
    task automatic test_utf16_pairing();
        set_encodings(utc_pkg::ENC_UTF16, utc_pkg::ENC_UTF8);
        send_word(8'h00, 1'b0);
        send_word(8'hD8, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hDC, 1'b0);
        send_word(8'h12, 1'b1);
    endtask

    // oversized utf-32 into utf-16, substitution into single byte,
    // stream ending on a pending high surrogate, single-byte source
    task automatic test_oversize_and_subst();
        set_encodings(utc_pkg::ENC_UTF32, utc_pkg::ENC_UTF16);
        repeat (4) send_word(8'hFF, 1'b0);
        set_encodings(utc_pkg::ENC_UTF16, utc_pkg::ENC_SINGLE);
        send_word(8'h00, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hD8, 1'b1);
        set_encodings(utc_pkg::ENC_SINGLE, utc_pkg::ENC_UTF8);
        send_word(8'hFF, 1'b1);
    endtask

    // a register write drops a half-built character
    task automatic test_config_clears_state();
        set_encodings(utc_pkg::ENC_UTF8, utc_pkg::ENC_UTF16);
        send_word(8'hC3, 1'b0);
        set_encodings(utc_pkg::ENC_UTF8, utc_pkg::ENC_UTF16);
        send_word(8'h41, 1'b0);
    endtask

    task automatic random_phase(input utc_pkg::enc_t s, input utc_pkg::enc_t d,
                                input int n);
        int start;
        start = items_sent;
        set_encodings(s, d);
        while (items_sent - start < n)
        begin
            // mostly real characters, some raw noise bytes
            if ($urandom_range(0, 3) == 0)
                send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            else
                send_char(s);
            if ($urandom_range(0, 49) == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_random_streams();
        random_phase(utc_pkg::ENC_UTF8, utc_pkg::ENC_UTF16, 30);
        random_phase(utc_pkg::ENC_UTF16, utc_pkg::ENC_UTF8, 30);
        random_phase(utc_pkg::ENC_UTF32, utc_pkg::ENC_UTF8, 30);
        random_phase(utc_pkg::ENC_UTF8, utc_pkg::ENC_UTF32, 30);
        random_phase(utc_pkg::ENC_SINGLE, utc_pkg::ENC_UTF32, 30);
        random_phase(utc_pkg::ENC_UTF32, utc_pkg::ENC_SINGLE, 30);
        random_phase(utc_pkg::ENC_UTF16, utc_pkg::ENC_UTF32, 30);
        random_phase(utc_pkg::ENC_UTF32, utc_pkg::ENC_UTF16, 30);
        random_phase(utc_pkg::ENC_UTF8, utc_pkg::ENC_SINGLE, 30);
        random_phase(utc_pkg::ENC_UTF32, utc_pkg::ENC_UTF32, 30);
    endtask

    // receiver stall pattern: free runs, solid stalls and choppy stretches
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    out_stall <= 1'b0;
                    stall_left <= $urandom_range(10, 40);
                end
                1:
                begin
                    out_stall <= 1'b1;
                    stall_left <= $urandom_range(1, 8);
                end
                default:
                begin
                    out_stall <= 1'($urandom_range(0, 1));
                    stall_left <= $urandom_range(0, 2);
                end
            endcase
        end
    end

    // compare each accepted output word with the oldest owed byte
    always @(posedge clk)
    begin : check_out
        utc_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_bytes.size() == 0)
                report_mismatch("unexpected word, out_byte", out_data.out_byte, 8'h00);
            else
            begin
                want = owed_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_data.out_byte, want.out_byte);
                if (out_data.out_last !== want.out_last)
                    report_mismatch("out_last", 8'(out_data.out_last), 8'(want.out_last));
                if (out_data.out_truncated !== want.out_truncated)
                    report_mismatch("out_truncated", 8'(out_data.out_truncated),
                                    8'(want.out_truncated));
            end
        end
    end

    initial
    begin
        // falling edge seen by the block before its first clock
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_utf8_leads();
        test_utf16_pairing();
        test_oversize_and_subst();
        test_config_clears_state();
        test_random_streams();

        // let everything owed come out, then watch for strays
        in_valid <= 1'b0;
        while (owed_bytes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("unicode_transcoder: match");
        else
            $display("unicode_transcoder: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/utc_pkg.sv
hdl/utc_encode.sv
hdl/unicode_transcoder.sv
test/tb_unicode_transcoder.sv
